// ===== rtl/tcc_pkg.sv =====
// Shared constants for the triangle circumcircle test block.
// No dependencies; every other file in rtl/ refers to this package.
`timescale 1ns / 1ps

package tcc_pkg;

	localparam int COORD_BITS_DEF = 12;  // vertex coordinate width
	localparam int FRAC_BITS_DEF  = 4;   // fraction bits of the centre
	localparam int CENTER_W       = 41;  // centre output width
	localparam int RADIUS_W       = 63;  // squared radius output width

endpackage

// ===== rtl/tcc_if.sv =====
// Valid/ready channel interfaces: triangle items in, circle results out.
// Depends on tcc_pkg for default and fixed widths.
`timescale 1ns / 1ps

interface tcc_item_if #(
	parameter int CB = tcc_pkg::COORD_BITS_DEF
) ();
	logic valid;
	logic ready;
	logic signed [CB-1:0] ax, ay, bx, by_coord, cx, cy, qx, qy;

	modport source (output valid, ax, ay, bx, by_coord, cx, cy, qx, qy, input ready);
	modport sink (input valid, ax, ay, bx, by_coord, cx, cy, qx, qy, output ready);
endinterface

interface tcc_result_if ();
	logic valid;
	logic ready;
	logic signed [tcc_pkg::CENTER_W-1:0] center_x, center_y;
	logic [tcc_pkg::RADIUS_W-1:0] radius_sq;
	logic inside_res;
	logic degenerate;

	modport source (output valid, center_x, center_y, radius_sq, inside_res, degenerate,
		input ready);
	modport sink (input valid, center_x, center_y, radius_sq, inside_res, degenerate,
		output ready);
endinterface

// ===== rtl/triangle_circumcircle_test.sv =====
// Triangle circumcircle / Delaunay in-circle pipeline, top level.
// Depends on tcc_pkg and the channel interfaces in tcc_if.sv.
//
// One transaction is accepted every clock cycle while the result channel is
// ready or any stage is empty. The pipeline depth is set by the 63-stage
// restoring divider for the squared radius, which runs alongside the two
// centre dividers (one quotient bit per stage). Ten front stages compute the
// differences, products, bisector numerators, in-circle determinant, the
// radius numerator and denominator and the radius saturation check; two end
// stages apply the floor, add the first vertex, saturate, and zero the outputs
// of a collinear triangle. Each stage holds its own valid bit, so a stall only
// backs up as far as the first empty stage and the block keeps accepting while
// a result waits and any stage is still empty.
`timescale 1ns / 1ps

module triangle_circumcircle_test #(
	parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = tcc_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tcc_item_if.sink     item,
	tcc_result_if.source result
);

	localparam int C     = COORD_BITS;
	localparam int CW    = tcc_pkg::CENTER_W;
	localparam int QR    = tcc_pkg::RADIUS_W;
	localparam int DFW   = C + 1;            // vertex differences
	localparam int PW    = 2 * DFW;          // difference products
	localparam int SW    = PW + 1;           // cr, b2, c2, q2, cqc, cbq
	localparam int P4W   = DFW + SW;         // cy*b2 and friends
	localparam int NXW   = P4W + 1;          // bisector numerators
	localparam int NXM   = NXW;              // their magnitudes
	localparam int FPW   = 2 * SW;           // in-circle products
	localparam int FW    = FPW + 2;          // in-circle determinant
	localparam int DMW   = SW + 1;           // |2*cr|
	localparam int LO    = NXM / 2;
	localparam int HI    = NXM - LO;
	localparam int NUMW  = 2 * NXM + 1;
	localparam int DENW  = 2 * DMW;
	localparam int QWC   = NXM + FRAC_BITS;  // centre quotient bits
	localparam int CCW   = DMW + QWC + 1;
	localparam int RCW   = ((NUMW > DENW + QR) ? NUMW : DENW + QR) + 1;
	localparam int NDIV  = (QWC > QR) ? QWC : QR;
	localparam int CQW   = QWC + 2;
	localparam int CVW   = (CQW + 1 > CW + 1) ? CQW + 1 : CW + 1;
	localparam int S_DIV0 = 10;
	localparam int S_F1   = S_DIV0 + NDIV;
	localparam int S_F2   = S_F1 + 1;
	localparam int NST    = S_F2 + 1;

	localparam logic signed [CVW-1:0] CMAX = $signed({{(CVW-CW+1){1'b0}}, {(CW-1){1'b1}}});
	localparam logic signed [CVW-1:0] CMIN = $signed({{(CVW-CW+1){1'b1}}, {(CW-1){1'b0}}});

	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;

	// A stage may load when the result channel is ready, or when it or any stage further on is empty.
	always_comb begin
		for (int k = 0; k < NST; k++) begin
			en[k] = result.ready || (((~vld_q) >> k) != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= item.valid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign item.ready   = en[0];
	assign result.valid = vld_q[NST-1];

	// s1: differences against vertex a
	logic signed [DFW-1:0] bx_s1, by_s1, cx_s1, cy_s1, qx_s1, qy_s1;
	logic signed [C-1:0]   ax_s1, ay_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			bx_s1 <= DFW'($signed(item.bx)) - DFW'($signed(item.ax));
			by_s1 <= DFW'($signed(item.by_coord)) - DFW'($signed(item.ay));
			cx_s1 <= DFW'($signed(item.cx)) - DFW'($signed(item.ax));
			cy_s1 <= DFW'($signed(item.cy)) - DFW'($signed(item.ay));
			qx_s1 <= DFW'($signed(item.qx)) - DFW'($signed(item.ax));
			qy_s1 <= DFW'($signed(item.qy)) - DFW'($signed(item.ay));
			ax_s1 <= item.ax;
			ay_s1 <= item.ay;
		end
	end

	// s2: pairwise products of the differences
	logic signed [PW-1:0] bxcy_s2, bycx_s2, bxbx_s2, byby_s2, cxcx_s2, cycy_s2;
	logic signed [PW-1:0] qxqx_s2, qyqy_s2, qxcy_s2, qycx_s2, bxqy_s2, byqx_s2;
	logic signed [DFW-1:0] bx_s2, by_s2, cx_s2, cy_s2;
	logic signed [C-1:0]   ax_s2, ay_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			bxcy_s2 <= PW'(bx_s1) * PW'(cy_s1);
			bycx_s2 <= PW'(by_s1) * PW'(cx_s1);
			bxbx_s2 <= PW'(bx_s1) * PW'(bx_s1);
			byby_s2 <= PW'(by_s1) * PW'(by_s1);
			cxcx_s2 <= PW'(cx_s1) * PW'(cx_s1);
			cycy_s2 <= PW'(cy_s1) * PW'(cy_s1);
			qxqx_s2 <= PW'(qx_s1) * PW'(qx_s1);
			qyqy_s2 <= PW'(qy_s1) * PW'(qy_s1);
			qxcy_s2 <= PW'(qx_s1) * PW'(cy_s1);
			qycx_s2 <= PW'(qy_s1) * PW'(cx_s1);
			bxqy_s2 <= PW'(bx_s1) * PW'(qy_s1);
			byqx_s2 <= PW'(by_s1) * PW'(qx_s1);
			bx_s2 <= bx_s1;
			by_s2 <= by_s1;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
		end
	end

	// s3: cross product, squared lengths, query cross terms
	logic signed [SW-1:0]  cr_s3, b2_s3, c2_s3, q2_s3, cqc_s3, cbq_s3;
	logic signed [DFW-1:0] bx_s3, by_s3, cx_s3, cy_s3;
	logic signed [C-1:0]   ax_s3, ay_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			cr_s3  <= SW'(bxcy_s2) - SW'(bycx_s2);
			b2_s3  <= SW'(bxbx_s2) + SW'(byby_s2);
			c2_s3  <= SW'(cxcx_s2) + SW'(cycy_s2);
			q2_s3  <= SW'(qxqx_s2) + SW'(qyqy_s2);
			cqc_s3 <= SW'(qxcy_s2) - SW'(qycx_s2);
			cbq_s3 <= SW'(bxqy_s2) - SW'(byqx_s2);
			bx_s3 <= bx_s2;
			by_s3 <= by_s2;
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
		end
	end

	// s4: numerator and determinant products
	logic signed [P4W-1:0] cyb2_s4, byc2_s4, bxc2_s4, cxb2_s4;
	logic signed [FPW-1:0] fa_s4, fb_s4, fc_s4;
	logic signed [SW-1:0]  cr_s4;
	logic                  dgn_s4;
	logic signed [C-1:0]   ax_s4, ay_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			cyb2_s4 <= P4W'(cy_s3) * P4W'(b2_s3);
			byc2_s4 <= P4W'(by_s3) * P4W'(c2_s3);
			bxc2_s4 <= P4W'(bx_s3) * P4W'(c2_s3);
			cxb2_s4 <= P4W'(cx_s3) * P4W'(b2_s3);
			fa_s4   <= FPW'(q2_s3) * FPW'(cr_s3);
			fb_s4   <= FPW'(b2_s3) * FPW'(cqc_s3);
			fc_s4   <= FPW'(c2_s3) * FPW'(cbq_s3);
			cr_s4   <= cr_s3;
			dgn_s4  <= (cr_s3 == '0);
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;
		end
	end

	// s5: bisector numerators, in-circle determinant, d = 2*cr
	logic signed [NXW-1:0] nx_s5, ny_s5;
	logic signed [FW-1:0]  f_s5;
	logic signed [DMW-1:0] d_s5;
	logic                  dgn_s5;
	logic signed [C-1:0]   ax_s5, ay_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			nx_s5  <= NXW'(cyb2_s4) - NXW'(byc2_s4);
			ny_s5  <= NXW'(bxc2_s4) - NXW'(cxb2_s4);
			f_s5   <= FW'(fa_s4) - FW'(fb_s4) - FW'(fc_s4);
			d_s5   <= DMW'(cr_s4) <<< 1;
			dgn_s5 <= dgn_s4;
			ax_s5  <= ax_s4;
			ay_s5  <= ay_s4;
		end
	end

	// s6: magnitudes and signs; in-circle decision
	logic [NXM-1:0]      nxm_s6, nym_s6;
	logic [DMW-1:0]      dm_s6;
	logic                sx_s6, sy_s6, ins_s6, dgn_s6;
	logic signed [C-1:0] ax_s6, ay_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			nxm_s6 <= nx_s5[NXW-1] ? NXM'(-nx_s5) : NXM'(nx_s5);
			nym_s6 <= ny_s5[NXW-1] ? NXM'(-ny_s5) : NXM'(ny_s5);
			dm_s6  <= d_s5[DMW-1] ? DMW'(-d_s5) : DMW'(d_s5);
			sx_s6  <= nx_s5[NXW-1] ^ d_s5[DMW-1];
			sy_s6  <= ny_s5[NXW-1] ^ d_s5[DMW-1];
			// counter-clockwise: inside when f <= 0, clockwise when f >= 0
			ins_s6 <= d_s5[DMW-1] ? !f_s5[FW-1] : (f_s5[FW-1] || (f_s5 == '0));
			dgn_s6 <= dgn_s5;
			ax_s6  <= ax_s5;
			ay_s6  <= ay_s5;
		end
	end

	// s7: partial products of the squared numerators, squared denominator
	logic [2*HI-1:0]     xhh_s7, yhh_s7;
	logic [HI+LO-1:0]    xhl_s7, yhl_s7;
	logic [2*LO-1:0]     xll_s7, yll_s7;
	logic [DENW-1:0]     den_s7;
	logic [NXM-1:0]      nxm_s7, nym_s7;
	logic [DMW-1:0]      dm_s7;
	logic                sx_s7, sy_s7, ins_s7, dgn_s7;
	logic signed [C-1:0] ax_s7, ay_s7;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			xhh_s7 <= (2*HI)'(nxm_s6[NXM-1:LO]) * (2*HI)'(nxm_s6[NXM-1:LO]);
			xhl_s7 <= (HI+LO)'(nxm_s6[NXM-1:LO]) * (HI+LO)'(nxm_s6[LO-1:0]);
			xll_s7 <= (2*LO)'(nxm_s6[LO-1:0]) * (2*LO)'(nxm_s6[LO-1:0]);
			yhh_s7 <= (2*HI)'(nym_s6[NXM-1:LO]) * (2*HI)'(nym_s6[NXM-1:LO]);
			yhl_s7 <= (HI+LO)'(nym_s6[NXM-1:LO]) * (HI+LO)'(nym_s6[LO-1:0]);
			yll_s7 <= (2*LO)'(nym_s6[LO-1:0]) * (2*LO)'(nym_s6[LO-1:0]);
			den_s7 <= DENW'(dm_s6) * DENW'(dm_s6);
			nxm_s7 <= nxm_s6;
			nym_s7 <= nym_s6;
			dm_s7  <= dm_s6;
			sx_s7  <= sx_s6;
			sy_s7  <= sy_s6;
			ins_s7 <= ins_s6;
			dgn_s7 <= dgn_s6;
			ax_s7  <= ax_s6;
			ay_s7  <= ay_s6;
		end
	end

	// s8: nx^2 and ny^2
	logic [NUMW-1:0]     sqx_s8, sqy_s8;
	logic [DENW-1:0]     den_s8;
	logic [NXM-1:0]      nxm_s8, nym_s8;
	logic [DMW-1:0]      dm_s8;
	logic                sx_s8, sy_s8, ins_s8, dgn_s8;
	logic signed [C-1:0] ax_s8, ay_s8;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			sqx_s8 <= (NUMW'(xhh_s7) << (2*LO)) + (NUMW'(xhl_s7) << (LO+1)) + NUMW'(xll_s7);
			sqy_s8 <= (NUMW'(yhh_s7) << (2*LO)) + (NUMW'(yhl_s7) << (LO+1)) + NUMW'(yll_s7);
			den_s8 <= den_s7;
			nxm_s8 <= nxm_s7;
			nym_s8 <= nym_s7;
			dm_s8  <= dm_s7;
			sx_s8  <= sx_s7;
			sy_s8  <= sy_s7;
			ins_s8 <= ins_s7;
			dgn_s8 <= dgn_s7;
			ax_s8  <= ax_s7;
			ay_s8  <= ay_s7;
		end
	end

	// s9: radius numerator
	logic [NUMW-1:0]     num_s9;
	logic [DENW-1:0]     den_s9;
	logic [NXM-1:0]      nxm_s9, nym_s9;
	logic [DMW-1:0]      dm_s9;
	logic                sx_s9, sy_s9, ins_s9, dgn_s9;
	logic signed [C-1:0] ax_s9, ay_s9;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			num_s9 <= sqx_s8 + sqy_s8;
			den_s9 <= den_s8;
			nxm_s9 <= nxm_s8;
			nym_s9 <= nym_s8;
			dm_s9  <= dm_s8;
			sx_s9  <= sx_s8;
			sy_s9  <= sy_s8;
			ins_s9 <= ins_s8;
			dgn_s9 <= dgn_s8;
			ax_s9  <= ax_s8;
			ay_s9  <= ay_s8;
		end
	end

	// s10: radius saturation check - quotient would not fit in QR bits
	logic [NUMW-1:0]     num_s10;
	logic [DENW-1:0]     den_s10;
	logic [NXM-1:0]      nxm_s10, nym_s10;
	logic [DMW-1:0]      dm_s10;
	logic                sx_s10, sy_s10, ins_s10, dgn_s10, rsat_s10;
	logic signed [C-1:0] ax_s10, ay_s10;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			rsat_s10 <= RCW'(num_s9) >= (RCW'(den_s9) << QR);
			num_s10  <= num_s9;
			den_s10  <= den_s9;
			nxm_s10  <= nxm_s9;
			nym_s10  <= nym_s9;
			dm_s10   <= dm_s9;
			sx_s10   <= sx_s9;
			sy_s10   <= sy_s9;
			ins_s10  <= ins_s9;
			dgn_s10  <= dgn_s9;
			ax_s10   <= ax_s9;
			ay_s10   <= ay_s9;
		end
	end

	// Divider stages: one restoring step per stage for each of the three quotients until its bits are done
	logic [CCW-1:0]      xrem_sd [NDIV];
	logic [CCW-1:0]      yrem_sd [NDIV];
	logic [QWC-1:0]      xq_sd   [NDIV];
	logic [QWC-1:0]      yq_sd   [NDIV];
	logic [RCW-1:0]      rrem_sd [NDIV];
	logic [QR-1:0]       rq_sd   [NDIV];
	logic [DMW-1:0]      dm_sd   [NDIV];
	logic [DENW-1:0]     den_sd  [NDIV];
	logic                sx_sd   [NDIV];
	logic                sy_sd   [NDIV];
	logic                ins_sd  [NDIV];
	logic                dgn_sd  [NDIV];
	logic                rsat_sd [NDIV];
	logic signed [C-1:0] ax_sd   [NDIV];
	logic signed [C-1:0] ay_sd   [NDIV];

	for (genvar j = 0; j < NDIV; j++) begin : g_div
		localparam int XI = QWC - 1 - j;
		localparam int RI = QR - 1 - j;

		logic [CCW-1:0]      xr_i, yr_i, xr_o, yr_o;
		logic [QWC-1:0]      xq_i, yq_i, xq_o, yq_o;
		logic [RCW-1:0]      rr_i, rr_o;
		logic [QR-1:0]       rq_i, rq_o;
		logic [DMW-1:0]      dm_i;
		logic [DENW-1:0]     den_i;
		logic                sx_i, sy_i, ins_i, dgn_i, rsat_i;
		logic signed [C-1:0] ax_i, ay_i;

		if (j == 0) begin : g_src
			assign xr_i   = CCW'(nxm_s10) << FRAC_BITS;
			assign yr_i   = CCW'(nym_s10) << FRAC_BITS;
			assign xq_i   = '0;
			assign yq_i   = '0;
			assign rr_i   = RCW'(num_s10);
			assign rq_i   = '0;
			assign dm_i   = dm_s10;
			assign den_i  = den_s10;
			assign sx_i   = sx_s10;
			assign sy_i   = sy_s10;
			assign ins_i  = ins_s10;
			assign dgn_i  = dgn_s10;
			assign rsat_i = rsat_s10;
			assign ax_i   = ax_s10;
			assign ay_i   = ay_s10;
		end else begin : g_src
			assign xr_i   = xrem_sd[j-1];
			assign yr_i   = yrem_sd[j-1];
			assign xq_i   = xq_sd[j-1];
			assign yq_i   = yq_sd[j-1];
			assign rr_i   = rrem_sd[j-1];
			assign rq_i   = rq_sd[j-1];
			assign dm_i   = dm_sd[j-1];
			assign den_i  = den_sd[j-1];
			assign sx_i   = sx_sd[j-1];
			assign sy_i   = sy_sd[j-1];
			assign ins_i  = ins_sd[j-1];
			assign dgn_i  = dgn_sd[j-1];
			assign rsat_i = rsat_sd[j-1];
			assign ax_i   = ax_sd[j-1];
			assign ay_i   = ay_sd[j-1];
		end

		if (XI >= 0) begin : g_cstep
			logic [CCW-1:0] xt, yt;
			assign xt   = xr_i - (CCW'(dm_i) << XI);
			assign yt   = yr_i - (CCW'(dm_i) << XI);
			assign xr_o = xt[CCW-1] ? xr_i : xt;
			assign yr_o = yt[CCW-1] ? yr_i : yt;
			assign xq_o = xq_i | (QWC'(!xt[CCW-1]) << XI);
			assign yq_o = yq_i | (QWC'(!yt[CCW-1]) << XI);
		end else begin : g_cstep
			assign xr_o = xr_i;
			assign yr_o = yr_i;
			assign xq_o = xq_i;
			assign yq_o = yq_i;
		end

		if (RI >= 0) begin : g_rstep
			logic [RCW-1:0] rt;
			assign rt   = rr_i - (RCW'(den_i) << RI);
			assign rr_o = rt[RCW-1] ? rr_i : rt;
			assign rq_o = rq_i | (QR'(!rt[RCW-1]) << RI);
		end else begin : g_rstep
			assign rr_o = rr_i;
			assign rq_o = rq_i;
		end

		always_ff @(posedge clk) begin
			if (en[S_DIV0+j]) begin
				xrem_sd[j] <= xr_o;
				yrem_sd[j] <= yr_o;
				xq_sd[j]   <= xq_o;
				yq_sd[j]   <= yq_o;
				rrem_sd[j] <= rr_o;
				rq_sd[j]   <= rq_o;
				dm_sd[j]   <= dm_i;
				den_sd[j]  <= den_i;
				sx_sd[j]   <= sx_i;
				sy_sd[j]   <= sy_i;
				ins_sd[j]  <= ins_i;
				dgn_sd[j]  <= dgn_i;
				rsat_sd[j] <= rsat_i;
				ax_sd[j]   <= ax_i;
				ay_sd[j]   <= ay_i;
			end
		end
	end

	// f1: signed floor quotient, radius saturation
	logic signed [CQW-1:0] xmag, ymag;
	logic                  xnz, ynz;

	assign xmag = $signed({2'b00, xq_sd[NDIV-1]});
	assign ymag = $signed({2'b00, yq_sd[NDIV-1]});
	assign xnz  = (xrem_sd[NDIV-1] != '0);
	assign ynz  = (yrem_sd[NDIV-1] != '0);

	logic signed [CQW-1:0] xc_sf1, yc_sf1;
	logic [QR-1:0]         rad_sf1;
	logic                  ins_sf1, dgn_sf1;
	logic signed [C-1:0]   ax_sf1, ay_sf1;

	always_ff @(posedge clk) begin
		if (en[S_F1]) begin
			// negative quotient with a remainder rounds one further down
			xc_sf1  <= sx_sd[NDIV-1] ? (-xmag - CQW'(xnz)) : xmag;
			yc_sf1  <= sy_sd[NDIV-1] ? (-ymag - CQW'(ynz)) : ymag;
			rad_sf1 <= rsat_sd[NDIV-1] ? {QR{1'b1}} : rq_sd[NDIV-1];
			ins_sf1 <= ins_sd[NDIV-1];
			dgn_sf1 <= dgn_sd[NDIV-1];
			ax_sf1  <= ax_sd[NDIV-1];
			ay_sf1  <= ay_sd[NDIV-1];
		end
	end

	// f2: add vertex a, saturate, zero a degenerate result
	logic signed [CVW-1:0] xv, yv;
	logic signed [CVW-1:0] xs, ys;

	assign xv = CVW'(xc_sf1) + (CVW'(ax_sf1) <<< FRAC_BITS);
	assign yv = CVW'(yc_sf1) + (CVW'(ay_sf1) <<< FRAC_BITS);
	assign xs = (xv > CMAX) ? CMAX : ((xv < CMIN) ? CMIN : xv);
	assign ys = (yv > CMAX) ? CMAX : ((yv < CMIN) ? CMIN : yv);

	logic signed [CW-1:0] cx_sf2, cy_sf2;
	logic [QR-1:0]        rad_sf2;
	logic                 ins_sf2, dgn_sf2;

	always_ff @(posedge clk) begin
		if (en[S_F2]) begin
			cx_sf2  <= dgn_sf1 ? '0 : xs[CW-1:0];
			cy_sf2  <= dgn_sf1 ? '0 : ys[CW-1:0];
			rad_sf2 <= dgn_sf1 ? '0 : rad_sf1;
			ins_sf2 <= dgn_sf1 ? 1'b0 : ins_sf1;
			dgn_sf2 <= dgn_sf1;
		end
	end

	assign result.center_x   = cx_sf2;
	assign result.center_y   = cy_sf2;
	assign result.radius_sq  = rad_sf2;
	assign result.inside_res = ins_sf2;
	assign result.degenerate = dgn_sf2;

`ifndef SYNTHESIS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.degenerate |->
			result.center_x == '0 && result.center_y == '0 &&
			result.radius_sq == '0 && !result.inside_res)
		else $error("degenerate result with nonzero fields");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> &vld_q)
		else $error("input blocked while pipeline has an empty stage");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> vld_q[0])
		else $error("accepted transaction missing from first stage");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !vld_q[NST-2] |=> !result.valid)
		else $error("result repeated after it was taken");
`endif

endmodule

// ===== bench/circumcircle_checker.sv =====
// Watches the item and result channels, predicts each circle result and compares.
// Depends on tcc_pkg and the channel interfaces in rtl/tcc_if.sv.
`timescale 1ns / 1ps

module circumcircle_checker (
	input  logic         clk,
	input  logic         arst_n,
	tcc_item_if          item,
	tcc_result_if        result,
	output int           errors,
	output int           pending
);

	localparam int CB = tcc_pkg::COORD_BITS_DEF;
	localparam int CW = tcc_pkg::CENTER_W;
	localparam int RW = tcc_pkg::RADIUS_W;
	localparam longint SCALE = longint'(1) << tcc_pkg::FRAC_BITS_DEF;
	localparam longint CENTRE_HI = (longint'(1) << (CW - 1)) - 1;
	localparam longint CENTRE_LO = -(longint'(1) << (CW - 1));

	typedef struct {
		logic signed [CW-1:0] centre_x;
		logic signed [CW-1:0] centre_y;
		logic [RW-1:0]        rad_sq;
		logic                 in_circ;
		logic                 collinear;
	} circle_t;

	circle_t expected_circles[$];

	function automatic logic signed [127:0] wide(input longint v);
		logic signed [127:0] r;
		r = 128'(v);
		return r;
	endfunction

	function automatic longint floor_quot(input longint n, input longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && ((n < 0) != (d < 0)))
			q--;
		return q;
	endfunction

	function automatic longint clamp_centre(input longint v);
		if (v > CENTRE_HI)
			return CENTRE_HI;
		if (v < CENTRE_LO)
			return CENTRE_LO;
		return v;
	endfunction

	function automatic circle_t solve_circle(input logic signed [CB-1:0] ax_i, ay_i, bx_i,
		by_i, cx_i, cy_i, qx_i, qy_i);
		longint ax, ay, bx, by, cx, cy, qx, qy, cr, b2, c2, q2, d, nx, ny, cqc, cbq;
		logic signed [127:0] det, num_s, den_s;
		logic [127:0] quo;
		circle_t r;
		ax = longint'(ax_i); ay = longint'(ay_i);
		bx = longint'(bx_i) - ax; by = longint'(by_i) - ay;
		cx = longint'(cx_i) - ax; cy = longint'(cy_i) - ay;
		qx = longint'(qx_i) - ax; qy = longint'(qy_i) - ay;
		cr = bx * cy - by * cx;
		r = '{default: '0};
		if (cr == 0) begin
			r.collinear = 1'b1;
			return r;
		end
		b2 = bx * bx + by * by;
		c2 = cx * cx + cy * cy;
		q2 = qx * qx + qy * qy;
		d = 2 * cr;
		nx = cy * b2 - by * c2;
		ny = bx * c2 - cx * b2;
		r.centre_x = CW'(clamp_centre(ax * SCALE + floor_quot(nx * SCALE, d)));
		r.centre_y = CW'(clamp_centre(ay * SCALE + floor_quot(ny * SCALE, d)));
		num_s = wide(nx) * wide(nx) + wide(ny) * wide(ny);
		den_s = wide(d) * wide(d);
		quo = 128'(num_s) / 128'(den_s);
		r.rad_sq = (quo > {65'b0, {RW{1'b1}}}) ? {RW{1'b1}} : quo[RW-1:0];
		cqc = qx * cy - qy * cx;
		cbq = bx * qy - by * qx;
		det = wide(q2) * wide(cr) - wide(b2) * wide(cqc) - wide(c2) * wide(cbq);
		r.in_circ = (cr > 0) ? (det <= 0) : (det >= 0);
		return r;
	endfunction

	assign pending = expected_circles.size();

	always @(posedge clk or negedge arst_n) begin
		circle_t exp_c;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (item.valid && item.ready)
				expected_circles.push_back(solve_circle(item.ax, item.ay, item.bx, item.by_coord,
					item.cx, item.cy, item.qx, item.qy));
			if (result.valid && result.ready) begin
				if (expected_circles.size() == 0) begin
					if (errors < 10)
						$display("unexpected result transaction at %0t", $realtime);
					errors <= errors + 1;
				end else begin
					exp_c = expected_circles.pop_front();
					if (result.center_x !== exp_c.centre_x || result.center_y !== exp_c.centre_y
						|| result.radius_sq !== exp_c.rad_sq || result.inside_res !== exp_c.in_circ
						|| result.degenerate !== exp_c.collinear) begin
						if (errors < 10)
							$display("mismatch: exp cx=%0d cy=%0d r2=%0d in=%0b deg=%0b got cx=%0d cy=%0d r2=%0d in=%0b deg=%0b",
								exp_c.centre_x, exp_c.centre_y, exp_c.rad_sq, exp_c.in_circ,
								exp_c.collinear, result.center_x, result.center_y,
								result.radius_sq, result.inside_res, result.degenerate);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ===== bench/triangle_circumcircle_test_test.sv =====
// Testbench top: clock, reset, triangle stimulus, result back-pressure and verdict.
// Depends on tcc_pkg, rtl/tcc_if.sv, the block and circumcircle_checker.
`timescale 1ns / 1ps

module triangle_circumcircle_test_test;

	localparam int CB = tcc_pkg::COORD_BITS_DEF;
	localparam int LIMIT = 300000;
	localparam int SETTLE = 200;

	typedef logic signed [CB-1:0] coord_t;

	logic clk;
	logic arst_n;
	int   errors, pending;
	int   send_idle, recv_stall, long_hold;

	tcc_item_if   item_ch ();
	tcc_result_if result_ch ();

	triangle_circumcircle_test dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	circumcircle_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// receiver: random stalls plus an optional long hold-off
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				result_ch.ready <= 1'b0;
				long_hold--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	task automatic send_triangle(input int ax, ay, bx, by, cx, cy, qx, qy);
		while ($urandom_range(99) < send_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.ax <= coord_t'(ax); item_ch.ay <= coord_t'(ay);
		item_ch.bx <= coord_t'(bx); item_ch.by_coord <= coord_t'(by);
		item_ch.cx <= coord_t'(cx); item_ch.cy <= coord_t'(cy);
		item_ch.qx <= coord_t'(qx); item_ch.qy <= coord_t'(qy);
		do
			@(posedge clk);
		while (!item_ch.ready);
	endtask

	function automatic coord_t any_coord();
		return coord_t'($urandom);
	endfunction

	function automatic coord_t near_coord(input int span);
		return coord_t'($urandom_range(2 * span) - span);
	endfunction

	task automatic random_triangles(input int count);
		coord_t ax, ay, bx, by, cx, cy, qx, qy;
		int kind, k;
		repeat (count) begin
			kind = $urandom_range(9);
			if (kind < 5) begin
				ax = any_coord(); ay = any_coord(); bx = any_coord();
				by = any_coord(); cx = any_coord(); cy = any_coord();
				qx = any_coord(); qy = any_coord();
			end else if (kind < 7) begin
				ax = near_coord(20); ay = near_coord(20); bx = near_coord(20);
				by = near_coord(20); cx = near_coord(20); cy = near_coord(20);
				qx = near_coord(30); qy = near_coord(30);
			end else if (kind == 7) begin
				// collinear: third vertex on the line through the first two
				ax = near_coord(300); ay = near_coord(300);
				bx = ax + near_coord(100); by = ay + near_coord(100);
				k = $urandom_range(6) - 3;
				cx = coord_t'(ax + k * (bx - ax)); cy = coord_t'(ay + k * (by - ay));
				qx = any_coord(); qy = any_coord();
			end else begin
				// near-flat triangle with a huge circle; the query is on a vertex or random
				ax = any_coord(); ay = any_coord(); bx = any_coord(); by = any_coord();
				cx = ax + (bx - ax) / 2 + near_coord(1); cy = ay + (by - ay) / 2 + near_coord(1);
				if ($urandom_range(1)) begin
					qx = bx; qy = by;
				end else begin
					qx = any_coord(); qy = any_coord();
				end
			end
			send_triangle(int'(ax), int'(ay), int'(bx), int'(by), int'(cx), int'(cy),
				int'(qx), int'(qy));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		send_idle = 0; recv_stall = 0; long_hold = 0;
		item_ch.valid <= 1'b0;
		item_ch.ax <= '0; item_ch.ay <= '0; item_ch.bx <= '0; item_ch.by_coord <= '0;
		item_ch.cx <= '0; item_ch.cy <= '0; item_ch.qx <= '0; item_ch.qy <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_triangle(0, 0, 4, 0, 0, 4, 1, 1);             // ccw, inside
		send_triangle(0, 0, 0, 4, 4, 0, 1, 1);             // cw, inside
		send_triangle(0, 0, 4, 0, 0, 4, 4, 4);             // on the circle
		send_triangle(0, 0, 0, 4, 4, 0, 4, 4);             // on the circle, cw
		send_triangle(0, 0, 4, 0, 0, 4, 9, 9);             // outside
		send_triangle(0, 0, 0, 4, 4, 0, -9, 9);            // outside, cw
		send_triangle(-2048, -2048, 2047, -2048, -2048, 2047, 2047, 2047);
		send_triangle(2047, 2047, -2048, 2047, 2047, -2048, -2048, -2048);
		send_triangle(-2048, -2048, 2047, 2047, 2047, 2046, 0, 0);   // huge radius
		send_triangle(-2048, -2048, 2047, 2047, 2046, 2047, -2048, 2047);
		send_triangle(-2048, -2048, 2047, 2047, 0, 0, 5, 5);          // collinear
		send_triangle(3, 3, 3, 3, 7, 1, 0, 0);                         // repeated vertex
		send_triangle(5, 5, 5, 5, 5, 5, 5, 5);                         // all equal
		send_triangle(0, 0, 1, 0, 0, 1, 0, 0);                         // q on a vertex
		send_triangle(-1, -1, 1, -1, 0, 1, 0, 0);                      // odd centre, flooring
		send_triangle(-3, 7, 11, -5, 2, 2047, -2048, 0);
		send_triangle(2047, -2048, -2048, 2047, 2047, 2047, -2048, -2048);
		send_triangle(-2048, 0, 2047, 1, 0, -2048, 2047, -2048);

		// random phases: free flow with a long hold-off, idle sender, stalls, both
		long_hold = 400;
		random_triangles(100);
		send_idle = 87; recv_stall = 0;
		random_triangles(100);
		send_idle = 0; recv_stall = 87;
		random_triangles(100);
		send_idle = 13; recv_stall = 13;
		random_triangles(100);
		item_ch.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
